// ===== rtl/core/mbh_pkg.sv =====
package mbh_pkg;

   localparam logic [31:0] MUR_M      = 32'h5bd1e995;
   localparam logic [31:0] SEED_RESET = 32'h11223344;

   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_TAIL = 2'd1;
   localparam logic [1:0] OP_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic        first;
      logic        last;
      logic [31:0] init;
      logic [31:0] word;
   } entry_type;

endpackage

// ===== rtl/core/mbh_front.sv =====
module mbh_front import mbh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last_item,
   input  logic [31:0] req_total_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_seed,
   input  logic        queue_full,
   output logic        push,
   output entry_type   push_entry
);

   logic        open_ff, open_in;
   logic [31:0] seed_ff, seed_in;
   logic [31:0] mask;

   assign req_stall = queue_full;
   assign csr_ready = 1'b1;
   assign push      = req_valid && !queue_full;

   always_comb begin
      case (req_byte_count)
         3'd1:    mask = 32'h000000ff;
         3'd2:    mask = 32'h0000ffff;
         default: mask = 32'h00ffffff;
      endcase
   end

   always_comb begin
      push_entry.first = !open_ff;
      push_entry.last  = req_last_item;
      push_entry.init  = req_total_length ^ seed_ff;
      if (req_byte_count >= 3'd4) begin
         push_entry.op   = OP_FULL;
         push_entry.word = req_data_word;
      end else if (req_byte_count == 3'd0) begin
         push_entry.op   = OP_NONE;
         push_entry.word = req_data_word;
      end else begin
         push_entry.op   = OP_TAIL;
         push_entry.word = req_data_word & mask;
      end
   end

   always_comb begin
      open_in = open_ff;
      if (push) begin
         open_in = !req_last_item;
      end
      seed_in = seed_ff;
      if (csr_valid) begin
         seed_in = csr_seed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         seed_ff <= SEED_RESET;
      end else begin
         open_ff <= open_in;
         seed_ff <= seed_in;
      end
   end

endmodule

// ===== rtl/core/mbh_queue.sv =====
module mbh_queue import mbh_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      empty,
   output entry_type head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   entry_type         slot_ff [DEPTH];
   logic [PW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]     count_ff, count_in;

   assign full  = (count_ff == FULL_COUNT);
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == LAST_SLOT) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == LAST_SLOT) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/mbh_back.sv =====
module mbh_back import mbh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        empty,
   input  entry_type   head,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash_value
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_K2   = 2'd1;
   localparam logic [1:0] ST_H    = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic        last_ff, last_in;
   logic [31:0] h_ff, h_in;
   logic [31:0] k_ff, k_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_hash_ff, rsp_hash_in;
   logic [31:0] h_base;
   logic [31:0] mul_a;
   logic [31:0] prod;
   logic        fin_fire;

   assign h_base   = head.first ? head.init : h_ff;
   assign pop      = (state_ff == ST_IDLE) && !empty;
   assign fin_fire = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);
   assign prod     = mul_a * MUR_M;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

   always_comb begin
      case (state_ff)
         ST_IDLE: mul_a = (head.op == OP_FULL) ? head.word : (h_base ^ head.word);
         ST_K2:   mul_a = k_ff ^ (k_ff >> 24);
         ST_H:    mul_a = h_ff;
         default: mul_a = h_ff ^ (h_ff >> 13);
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      h_in         = h_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hash_in  = rsp_hash_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               last_in = head.last;
               case (head.op)
                  OP_FULL: begin
                     h_in     = h_base;
                     k_in     = prod;
                     state_in = ST_K2;
                  end
                  OP_TAIL: begin
                     h_in     = prod;
                     state_in = head.last ? ST_FIN : ST_IDLE;
                  end
                  default: begin
                     h_in     = h_base;
                     state_in = head.last ? ST_FIN : ST_IDLE;
                  end
               endcase
            end
         end
         ST_K2: begin
            k_in     = prod;
            state_in = ST_H;
         end
         ST_H: begin
            h_in     = prod ^ k_ff;
            state_in = last_ff ? ST_FIN : ST_IDLE;
         end
         default: begin
            if (fin_fire) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = prod ^ (prod >> 15);
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      h_ff        <= h_in;
      k_ff        <= k_in;
      rsp_hash_ff <= rsp_hash_in;
   end

endmodule

// ===== rtl/core/murmur2_byte_hash_top.sv =====
// 32-bit MurmurHash2 over a message streamed as little-endian words, one word per req_ beat.
// The front takes a beat whenever the queue has room and marks the first beat of each message,
// where length XOR seed starts the hash; the back works off the queue with one shared 32x32
// multiplier: a full word steps through ST_IDLE, ST_K2 and ST_H, a short or empty beat ends in
// ST_IDLE, the last beat adds ST_FIN (held by rsp_stall), and a beat is popped only in ST_IDLE.
// The hash leaves through an output register on rsp_; csr_seed applies from the next message.
module murmur2_byte_hash_top import mbh_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last_item,
   input  logic [31:0] req_total_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_seed
);

   logic      queue_full;
   logic      queue_empty;
   logic      push;
   logic      pop;
   entry_type push_entry;
   entry_type head;

   mbh_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_word    (req_data_word),
      .req_byte_count   (req_byte_count),
      .req_last_item    (req_last_item),
      .req_total_length (req_total_length),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_seed         (csr_seed),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   mbh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .head       (head)
   );

   mbh_back u_back (
      .clock          (clock),
      .reset          (reset),
      .empty          (queue_empty),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

// ===== test/tb_murmur2_byte_hash_top.sv =====
`timescale 1ns / 100ps

module tb_murmur2_byte_hash_top;
   import mbh_pkg::*;

   localparam int          BEAT_TARGET    = 1800;
   localparam int          PHASE_BEATS    = 150;
   localparam int          CALM_TAIL      = 300;
   localparam int          SETTLE_CYCLES  = 24;
   localparam int          WATCHDOG_LIMIT = 4000;
   localparam logic [2:0]  FULL_WORD      = 3'd4;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  count;
      logic        last;
      logic [31:0] length;
   } beat_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [31:0] req_data_word    = '0;
   logic [2:0]  req_byte_count   = '0;
   logic        req_last_item    = 1'b0;
   logic [31:0] req_total_length = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [31:0] rsp_hash_value;
   logic        csr_valid        = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_seed         = '0;

   beat_type    pending[$];
   logic [31:0] hash_due[$];

   // predictor state
   logic [31:0] seed_model = SEED_RESET;
   logic [31:0] hash_acc   = '0;
   logic        msg_open   = 1'b0;

   bit          idle_on = 1'b1;
   int          req_gap = 0;
   int          rsp_hold = 0;
   int          quiet = 0;
   int          errors = 0;
   int          beats_queued = 0;
   int          beats_sent = 0;
   int          msgs_closed = 0;
   int          hashes_checked = 0;
   int          seeds_written = 0;

   murmur2_byte_hash_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_word    (req_data_word),
      .req_byte_count   (req_byte_count),
      .req_last_item    (req_last_item),
      .req_total_length (req_total_length),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hash_value   (rsp_hash_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_seed         (csr_seed)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic hash_absorb(input logic [31:0] w, input logic [2:0] n, input logic fin,
                              input logic [31:0] len);
      logic [31:0] h;
      logic [31:0] k;
      logic [31:0] mask;
      h = msg_open ? hash_acc : (len ^ seed_model);
      if (n >= FULL_WORD) begin
         k = w * MUR_M;
         k ^= k >> 24;
         k = k * MUR_M;
         h = (h * MUR_M) ^ k;
      end else if (n != 3'd0) begin
         mask = (n == 3'd3) ? 32'h00ffffff : (n == 3'd2) ? 32'h0000ffff : 32'h000000ff;
         h = (h ^ (w & mask)) * MUR_M;
      end
      if (fin) begin
         h ^= h >> 13;
         h = h * MUR_M;
         h ^= h >> 15;
         hash_due.push_back(h);
         hash_acc = '0;
         msg_open = 1'b0;
         msgs_closed++;
      end else begin
         hash_acc = h;
         msg_open = 1'b1;
      end
      beats_sent++;
   endtask

   always @(posedge clock) begin : driver
      beat_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
         hash_acc = '0;
         msg_open = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            hash_absorb(req_data_word, req_byte_count, req_last_item, req_total_length);
         end
         if (!req_valid || !req_stall) begin
            if (req_gap != 0) begin
               req_valid <= 1'b0;
               req_gap   <= req_gap - 1;
            end else if (pending.size() != 0) begin
               nxt = pending.pop_front();
               req_valid        <= 1'b1;
               req_data_word    <= nxt.word;
               req_byte_count   <= nxt.count;
               req_last_item    <= nxt.last;
               req_total_length <= nxt.length;
               if (idle_on && $urandom_range(0, 7) == 0) begin
                  req_gap <= $urandom_range(1, 18);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      logic [31:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold  <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (hash_due.size() == 0) begin
               $error("hash_value: no hash expected, got %h", rsp_hash_value);
               errors++;
            end else begin
               want = hash_due.pop_front();
               if (rsp_hash_value !== want) begin
                  $error("hash_value: expected %h, actual %h", want, rsp_hash_value);
                  errors++;
               end
               hashes_checked++;
            end
         end
         if (rsp_hold != 0) begin
            rsp_stall <= 1'b1;
            rsp_hold  <= rsp_hold - 1;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            rsp_hold  <= $urandom_range(0, 17);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d hashes outstanding",
                  quiet, hash_due.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic push_beat(input logic [31:0] w, input logic [2:0] n, input logic fin,
                            input logic [31:0] len);
      beat_type b;
      b.word   = w;
      b.count  = n;
      b.last   = fin;
      b.length = len;
      pending.push_back(b);
      beats_queued++;
   endtask

   // well-formed message: full words, closed by the last full word, a 1..3 byte tail or a zero-byte closer
   task automatic queue_message(input int unsigned nbytes, input bit exact_len);
      int unsigned n_full;
      int unsigned rem;
      bit          zero_end;
      bit          first;
      logic [31:0] len;
      n_full   = nbytes / 4;
      rem      = nbytes % 4;
      zero_end = (rem == 0) && (n_full == 0 || $urandom_range(0, 3) == 0);
      len      = exact_len ? nbytes : $urandom;
      first    = 1'b1;
      for (int unsigned i = 0; i < n_full; i++) begin
         push_beat($urandom, FULL_WORD, !zero_end && rem == 0 && i == n_full - 1,
                   first ? len : $urandom);
         first = 1'b0;
      end
      if (rem != 0) begin
         push_beat($urandom, rem[2:0], 1'b1, first ? len : $urandom);
      end else if (zero_end) begin
         push_beat($urandom, 3'd0, 1'b1, first ? len : $urandom);
      end
   endtask

   task automatic queue_noise();
      int unsigned nb;
      nb = $urandom_range(1, 6);
      for (int unsigned i = 0; i < nb; i++) begin
         push_beat($urandom, 3'($urandom_range(0, 7)), i == nb - 1, $urandom);
      end
   endtask

   task automatic drain();
      do @(posedge clock);
      while (beats_sent != beats_queued || hash_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_seed  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      seed_model = value;
      seeds_written++;
   endtask

   initial begin : stimulus
      int          phase;
      int          target;
      logic [31:0] seed_pick;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed, reset seed
      push_beat(32'h00000000, 3'd0, 1'b1, 32'h00000000);
      push_beat(32'hffffffff, FULL_WORD, 1'b1, 32'hffffffff);
      push_beat(32'hffffff80, 3'd1, 1'b1, 32'h00000001);
      push_beat(32'hffff8001, 3'd2, 1'b1, 32'h00000002);
      push_beat(32'hff010203, 3'd3, 1'b1, 32'h00000003);
      push_beat(32'h80000001, 3'd5, 1'b1, 32'h00000004);
      push_beat(32'h7ffffffe, 3'd6, 1'b1, 32'hffffffff);
      push_beat(32'hc3c3c3c3, 3'd7, 1'b1, 32'h00000008);
      // multi-beat with short and empty beats mid-message, length off
      push_beat(32'h01234567, FULL_WORD, 1'b0, 32'h0000000b);
      push_beat(32'h00000000, FULL_WORD, 1'b0, 32'hffffffff);
      push_beat(32'hdeadbeef, 3'd2, 1'b0, 32'h00000000);
      push_beat(32'hffffffff, 3'd0, 1'b0, 32'h12345678);
      push_beat(32'hfedcba98, 3'd3, 1'b1, 32'haaaaaaaa);
      // message left open across a seed change
      push_beat(32'h5a5a5a5a, FULL_WORD, 1'b0, 32'h80000000);
      push_beat(32'ha5a5a5a5, 3'd1, 1'b0, 32'h00000000);
      drain();
      write_seed(32'hffffffff);
      push_beat(32'h12345678, FULL_WORD, 1'b1, 32'h55555555);
      push_beat(32'h00000000, 3'd0, 1'b1, 32'h00000000);
      drain();
      write_seed(32'h00000000);
      push_beat(32'hcafef00d, FULL_WORD, 1'b1, 32'h00000004);
      drain();

      phase = 0;
      while (beats_queued < BEAT_TARGET) begin
         case (phase % 4)
            0:       seed_pick = 32'h00000000;
            1:       seed_pick = 32'hffffffff;
            default: seed_pick = $urandom;
         endcase
         write_seed(seed_pick);
         idle_on = (BEAT_TARGET - beats_queued > CALM_TAIL) && (phase % 3 != 2);
         target  = beats_queued + PHASE_BEATS;
         while (beats_queued < target) begin
            if ($urandom_range(0, 6) == 0) begin
               queue_noise();
            end else begin
               queue_message(($urandom_range(0, 9) == 0) ? $urandom_range(0, 200)
                                                         : $urandom_range(0, 24),
                             $urandom_range(0, 9) != 0);
            end
         end
         if (beats_queued < BEAT_TARGET && $urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) push_beat($urandom, 3'($urandom_range(0, 4)), 1'b0,
                                                    $urandom);
         end
         drain();
         phase++;
      end

      $display("covered %0d beats, %0d messages, %0d hashes checked", beats_sent,
               msgs_closed, hashes_checked);
      $display("seed register written %0d times, incl. all-zero and all-one", seeds_written);
      if (errors == 0 && hash_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/mbh_pkg.sv
rtl/core/mbh_front.sv
rtl/core/mbh_queue.sv
rtl/core/mbh_back.sv
rtl/core/murmur2_byte_hash_top.sv
test/tb_murmur2_byte_hash_top.sv
